// ===== design/lkv_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by every module of the block and by its checker.
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int DATA_BITS_DEF   = 32;
  localparam int FIELD_BITS      = 32;
  // widest storage word; the input key is zero-extended to this before trimming
  localparam int WIDE_BITS       = 64;
  localparam int CAP_BITS        = 5;

  localparam logic [CAP_BITS-1:0]   CAP_RESET  = 5'd16;
  localparam logic [FIELD_BITS-1:0] MISS_VALUE = '1;  // -1

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [FIELD_BITS-1:0] lookup_key;
    logic signed [FIELD_BITS-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic                         key_found;
    logic signed [FIELD_BITS-1:0] read_value;
    logic                         did_evict;
    logic signed [FIELD_BITS-1:0] evicted_key;
  } out_item_t;

endpackage

// ===== design/lkv_in_reg.sv =====
// Input register of the LRU key-value cache: holds one accepted item.
// Depends on lkv_pkg.
module lkv_in_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lkv_pkg::in_item_t in_item,
  input  logic             advance,
  output logic             held,
  output lkv_pkg::in_item_t held_item
);

  logic load;

  assign in_stall = held && !advance;
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== design/lkv_store.sv =====
// Entry store of the LRU key-value cache: per-entry valid, key, value and age,
// parallel key match, result forming and recency update. Depends on lkv_pkg.
module lkv_store #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int DATA_BITS   = lkv_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_wr_data,
  input  logic                          step,
  input  lkv_pkg::in_item_t             item,
  output lkv_pkg::out_item_t            result
);

  localparam int AGE_BITS = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_BITS = 8;
  localparam int EXT_BITS = DATA_BITS + lkv_pkg::FIELD_BITS;

  logic [lkv_pkg::CAP_BITS-1:0] capacity;
  logic [MAX_ENTRIES-1:0]       valid;
  logic [MAX_ENTRIES-1:0]       valid_next;
  logic [DATA_BITS-1:0]         keys   [MAX_ENTRIES];
  logic [DATA_BITS-1:0]         values [MAX_ENTRIES];
  logic [AGE_BITS-1:0]          ages      [MAX_ENTRIES];
  logic [AGE_BITS-1:0]          ages_next [MAX_ENTRIES];
  logic [CNT_BITS-1:0]          count;
  logic [CNT_BITS-1:0]          count_next;

  logic [lkv_pkg::WIDE_BITS-1:0] key_wide;
  logic [lkv_pkg::WIDE_BITS-1:0] val_wide;
  logic [DATA_BITS-1:0]          key_d;
  logic [DATA_BITS-1:0]          val_d;

  logic [LIM_BITS-1:0]    cap_ext;
  logic [LIM_BITS-1:0]    limit;
  logic                   full;
  logic [AGE_BITS-1:0]    last_age;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic [MAX_ENTRIES-1:0] free_vec;
  logic [MAX_ENTRIES-1:0] first_free;
  logic [MAX_ENTRIES-1:0] slot_vec;
  logic                   hit;
  logic                   is_put;
  logic                   insert;
  logic                   evict;
  logic [AGE_BITS-1:0]    hit_age;
  logic [DATA_BITS-1:0]   hit_value;
  logic [DATA_BITS-1:0]   victim_key;
  logic [EXT_BITS-1:0]    hit_value_ext;
  logic [EXT_BITS-1:0]    victim_key_ext;

  // storage keeps DATA_BITS of the zero-extended field
  assign key_wide = {{(lkv_pkg::WIDE_BITS - lkv_pkg::FIELD_BITS){1'b0}}, item.lookup_key};
  assign val_wide = {{(lkv_pkg::WIDE_BITS - lkv_pkg::FIELD_BITS){1'b0}}, item.write_value};
  assign key_d    = key_wide[DATA_BITS-1:0];
  assign val_d    = val_wide[DATA_BITS-1:0];

  // capacity zero acts as one, above the entry count saturates
  assign cap_ext = LIM_BITS'(capacity);
  always_comb begin
    if (cap_ext == '0) begin
      limit = LIM_BITS'(1);
    end else if (cap_ext > LIM_BITS'(MAX_ENTRIES)) begin
      limit = LIM_BITS'(MAX_ENTRIES);
    end else begin
      limit = cap_ext;
    end
  end

  assign full     = LIM_BITS'(count) >= limit;
  // valid ages are always 0 .. count-1, so the oldest one is count-1
  assign last_age = AGE_BITS'(count - CNT_BITS'(1));
  assign is_put   = item.cmd == lkv_pkg::CMD_PUT;

  always_comb begin
    hit_age    = '0;
    hit_value  = '0;
    victim_key = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (keys[i] == key_d);
      victim_vec[i] = valid[i] && (ages[i] == last_age);
      hit_age       = hit_age    | (hit_vec[i]    ? ages[i]   : '0);
      hit_value     = hit_value  | (hit_vec[i]    ? values[i] : '0);
      victim_key    = victim_key | (victim_vec[i] ? keys[i]   : '0);
    end
  end

  assign hit        = |hit_vec;
  assign insert     = is_put && !hit;
  assign evict      = insert && full;
  assign free_vec   = ~valid;
  assign first_free = free_vec & (~free_vec + MAX_ENTRIES'(1));
  assign slot_vec   = evict ? victim_vec : first_free;

  assign hit_value_ext  = {{lkv_pkg::FIELD_BITS{1'b0}}, hit_value};
  assign victim_key_ext = {{lkv_pkg::FIELD_BITS{1'b0}}, victim_key};

  always_comb begin
    result.key_found = hit;
    if (is_put) begin
      result.read_value = '0;
    end else if (hit) begin
      result.read_value = hit_value_ext[lkv_pkg::FIELD_BITS-1:0];
    end else begin
      result.read_value = lkv_pkg::MISS_VALUE;
    end
    result.did_evict   = evict;
    result.evicted_key = evict ? victim_key_ext[lkv_pkg::FIELD_BITS-1:0] : '0;
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ages_next[i] = ages[i];
      if (hit) begin
        if (hit_vec[i]) begin
          ages_next[i] = '0;
        end else if (valid[i] && ages[i] < hit_age) begin
          ages_next[i] = ages[i] + AGE_BITS'(1);
        end
      end else if (insert) begin
        if (slot_vec[i]) begin
          valid_next[i] = 1'b1;
          ages_next[i]  = '0;
        end else if (valid[i]) begin
          ages_next[i] = ages[i] + AGE_BITS'(1);
        end
      end
    end
    if (insert && !full) begin
      count_next = count + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
      valid    <= '0;
      count    <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
      valid    <= '0;
      count    <= '0;
    end else if (step) begin
      valid <= valid_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ages[i] <= ages_next[i];
        if ((insert && slot_vec[i]) || (is_put && hit_vec[i])) begin
          values[i] <= val_d;
        end
        if (insert && slot_vec[i]) begin
          keys[i] <= key_d;
        end
      end
    end
  end

endmodule

// ===== design/lkv_out_reg.sv =====
// Result register of the LRU key-value cache: holds one result item until taken.
// Depends on lkv_pkg.
module lkv_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  lkv_pkg::out_item_t result,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_stall,
  output lkv_pkg::out_item_t out_item
);

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// LRU key-value cache, top level.
//
// Input channel in_valid/in_stall/in_item carries get or put items; output
// channel out_valid/out_stall/out_item returns exactly one result item per
// input item, in order. An item is taken at an edge with valid high and
// stall low. cfg_wr_en/cfg_wr_data write the capacity register and empty
// the store; write it only when no item is in flight.
// An item passes from the input register through lkv_store into the result register,
// which is taken once out_stall is low. Throughput: one item per cycle while out_stall is low,
// set by the key match across all entries and age update in lkv_store.
// An output stall holds the result register; the item behind it waits in
// the input register and in_stall rises once both are occupied, so no item
// is lost. Reset empties the store and sets the capacity to 16; no clearing
// pass is needed since every entry has its own valid bit.
// Depends on lkv_pkg, lkv_in_reg, lkv_store and lkv_out_reg.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lkv_pkg::MAX_ENTRIES_DEF,
  parameter int DATA_BITS   = lkv_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [lkv_pkg::CAP_BITS-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lkv_pkg::in_item_t            in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lkv_pkg::out_item_t           out_item
);

  logic               advance;
  logic               held;
  logic               step;
  lkv_pkg::in_item_t  held_item;
  lkv_pkg::out_item_t result;

  assign step = held && advance;

  lkv_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .advance   (advance),
    .held      (held),
    .held_item (held_item)
  );

  lkv_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .DATA_BITS   (DATA_BITS)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .item        (held_item),
    .result      (result)
  );

  lkv_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== design/lkv_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level.
// Depends on lkv_pkg and lru_key_value_cache.
module lkv_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lkv_pkg::out_item_t out_item
);

  // a stalled result is not withdrawn
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // an eviction only comes from a put that missed
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.did_evict |->
      !out_item.key_found && out_item.read_value == '0)
    else $error("eviction on a hit or a get");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.did_evict |-> out_item.evicted_key == '0)
    else $error("evicted key without eviction");

  // nothing is in flight right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("output valid after reset");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== sim/lru_key_value_cache_test.sv =====
// Self-checking testbench for lru_key_value_cache: directed and random get/put items,
// with a shadow LRU store predicting every result and a scoreboard comparing them.
// Depends on lkv_pkg and lru_key_value_cache from the design folder.
module lru_key_value_cache_test;
  import lkv_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;

  class lru_shadow;
    logic                         used[DEPTH];
    logic signed [FIELD_BITS-1:0] keys[DEPTH];
    logic signed [FIELD_BITS-1:0] values[DEPTH];
    int unsigned                  ages[DEPTH];
    int unsigned                  fill;
    int unsigned                  capacity;
    out_item_t                    due_responses[$];
    int                           mismatches;

    function new();
      mismatches = 0;
      set_capacity(CAP_RESET);
    endfunction

    // any capacity write empties the store
    function void set_capacity(logic [CAP_BITS-1:0] cap);
      capacity = cap;
      fill = 0;
      for (int i = 0; i < DEPTH; i++) begin
        used[i] = 1'b0;
        ages[i] = 0;
      end
    endfunction

    // entries younger than the touched one grow one step older
    function void promote(int s);
      for (int i = 0; i < DEPTH; i++) begin
        if (used[i] && i != s && ages[i] < ages[s]) ages[i]++;
      end
      ages[s] = 0;
    endfunction

    function void note_request(in_item_t it);
      int        hit;
      int        slot;
      int        limit;
      out_item_t r;
      hit = -1;
      slot = -1;
      r = '0;
      for (int i = 0; i < DEPTH; i++) begin
        if (hit < 0 && used[i] && keys[i] == it.lookup_key) hit = i;
      end
      if (it.cmd == CMD_GET) begin
        if (hit >= 0) begin
          r.key_found = 1'b1;
          r.read_value = values[hit];
          promote(hit);
        end else begin
          r.read_value = MISS_VALUE;
        end
      end else if (hit >= 0) begin
        r.key_found = 1'b1;
        values[hit] = it.write_value;
        promote(hit);
      end else begin
        limit = (capacity < 1) ? 1 : (capacity > DEPTH) ? DEPTH : capacity;
        if (fill >= limit && fill > 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (used[i] && (slot < 0 || ages[i] > ages[slot])) slot = i;
          end
          r.did_evict = 1'b1;
          r.evicted_key = keys[slot];
          used[slot] = 1'b0;
          fill--;
        end else begin
          for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!used[i]) slot = i;
          end
        end
        if (slot >= 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (used[i]) ages[i]++;
          end
          used[slot] = 1'b1;
          keys[slot] = it.lookup_key;
          values[slot] = it.write_value;
          ages[slot] = 0;
          fill++;
        end
      end
      due_responses.push_back(r);
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (due_responses.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        mismatches++;
        return;
      end
      want = due_responses.pop_front();
      if (got.key_found !== want.key_found) begin
        $display("%0t: key_found expected %b got %b", $time, want.key_found, got.key_found);
        mismatches++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h got %h", $time, want.read_value, got.read_value);
        mismatches++;
      end
      if (got.did_evict !== want.did_evict) begin
        $display("%0t: did_evict expected %b got %b", $time, want.did_evict, got.did_evict);
        mismatches++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $display("%0t: evicted_key expected %h got %h", $time, want.evicted_key,
                 got.evicted_key);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [CAP_BITS-1:0] cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;

  lru_shadow shadow;
  bit        calm = 1'b0;
  bit        want_hold = 1'b0;
  int        hold_left = 0;

  lru_key_value_cache dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted items, then pick next cycle's stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) shadow.check_response(out_item);
    if (want_hold) begin
      want_hold = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 24);
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    in_item_t it;
    it.cmd = cmd;
    it.lookup_key = key;
    it.write_value = value;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.note_request(it);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (shadow.due_responses.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
    wait_for_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_capacity(cap);
  endtask

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CAP_BITS-1:0] phase_caps[10];
    logic [31:0]         key_pool[32];
    logic [31:0]         key;
    int                  eff;
    int                  pool_n;
    phase_caps = '{5'd3, 5'd16, 5'd31, 5'd0, 5'd1, 5'd8, 5'd17, 5'd5, 5'd16, 5'd2};
    shadow = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes at the reset capacity
    send_item(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_PUT, 32'h0000_0000, 32'h7fff_ffff);
    send_item(CMD_GET, 32'h0000_0000, 32'hffff_ffff);
    send_item(CMD_PUT, 32'hffff_ffff, 32'h8000_0000);
    send_item(CMD_PUT, 32'h7fff_ffff, 32'hffff_ffff);
    send_item(CMD_PUT, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'hffff_ffff, 32'h1234_5678);
    send_item(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    send_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    send_item(CMD_GET, 32'h5555_5555, 32'h0000_0000);
    // single entry: an insert into the full store evicts, update in place does not
    write_capacity(5'd1);
    send_item(CMD_PUT, 32'haaaa_aaaa, 32'h5555_5555);
    send_item(CMD_PUT, 32'h5555_5555, 32'haaaa_aaaa);
    send_item(CMD_GET, 32'haaaa_aaaa, 32'h0000_0000);
    send_item(CMD_PUT, 32'h5555_5555, 32'h0000_0001);
    send_item(CMD_GET, 32'h5555_5555, 32'h0000_0000);
    // zero capacity behaves as one
    write_capacity(5'd0);
    send_item(CMD_PUT, 32'h0000_0001, 32'h0000_0002);
    send_item(CMD_PUT, 32'h0000_0002, 32'h0000_0003);
    send_item(CMD_GET, 32'h0000_0002, 32'h0000_0000);
    // a get refreshes recency, so the other key is the one evicted
    write_capacity(5'd2);
    send_item(CMD_PUT, 32'd10, 32'd100);
    send_item(CMD_PUT, 32'd20, 32'd200);
    send_item(CMD_GET, 32'd10, 32'd0);
    send_item(CMD_PUT, 32'd30, 32'd300);
    send_item(CMD_GET, 32'd20, 32'd0);

    for (int p = 0; p < 10; p++) begin
      write_capacity(phase_caps[p]);
      calm = (p == 1);
      eff = (phase_caps[p] < 1) ? 1 : (phase_caps[p] > DEPTH) ? DEPTH : phase_caps[p];
      // a pool of twice the capacity, at least three keys, gives both hits and evictions
      pool_n = (2 * eff < 3) ? 3 : 2 * eff;
      for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
      for (int k = 0; k < 45; k++) begin
        if (p == 2 && k == 10) want_hold = 1'b1;
        if (p == 5 && k == 20) wait_for_drain();
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_n - 1)];
        else key = $urandom;
        // idle cycle by cycle, about a quarter of the time
        if (!calm) begin
          while ($urandom_range(99) < 24) begin
            in_valid <= 1'b0;
            @(posedge clk);
          end
        end
        send_item(1'($urandom_range(1)), key, $urandom);
      end
    end

    in_valid <= 1'b0;
    for (int n = 0; n < 2000 && shadow.due_responses.size() > 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.due_responses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, shadow.due_responses.size());
      shadow.mismatches++;
    end
    if (shadow.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
